// File: rtl/sedet_pkg.sv
package sedet_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_CHANNELS = 3'd0;
    localparam logic [2:0] REG_MID_SIDE = 3'd1;
    localparam logic [2:0] REG_SOURCE   = 3'd2;
    localparam logic [2:0] REG_MODE     = 3'd3;
    localparam logic [2:0] REG_WINDOW   = 3'd4;
    localparam logic [2:0] REG_GAIN     = 3'd5;
    localparam logic [2:0] REG_TAU      = 3'd6;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int WIN_BITS      = 13;
    localparam int COEF_BITS     = 16;
    localparam int GAIN_FRAC     = 12;
    localparam int LP_FRAC       = 16;

    // envelope modes
    localparam logic [1:0] MODE_PEAK = 2'd0;
    localparam logic [1:0] MODE_LP   = 2'd1;
    localparam logic [1:0] MODE_AVG  = 2'd2;
    localparam logic [1:0] MODE_RMS  = 2'd3;

    // source select
    localparam logic [1:0] SRC_LEFT  = 2'd0;
    localparam logic [1:0] SRC_RIGHT = 2'd1;
    localparam logic [1:0] SRC_MID   = 2'd2;
    localparam logic [1:0] SRC_SIDE  = 2'd3;

    localparam logic [1:0] CH_MONO   = 2'd1;
    localparam logic [1:0] CH_STEREO = 2'd2;

    // reset values
    localparam logic [1:0]           RST_CHANNELS = CH_STEREO;
    localparam logic                 RST_MID_SIDE = 1'b0;
    localparam logic [1:0]           RST_SOURCE   = SRC_MID;
    localparam logic [1:0]           RST_MODE     = MODE_RMS;
    localparam logic [WIN_BITS-1:0]  RST_WINDOW   = '0;
    localparam logic [COEF_BITS-1:0] RST_GAIN     = 16'd4096;
    localparam logic [COEF_BITS-1:0] RST_TAU      = 16'd65535;

    // status of an iterative unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

// File: rtl/sidechain_envelope_detector_unit.sv
// envelope detector for an audio sidechain
// input channel: i_in_valid / o_in_stall, one word is a sample pair
// (i_left_sample, i_right_sample); output channel: o_out_valid /
// i_out_stall carrying o_envelope. a word moves when valid is high and
// stall is low.
// configuration: i_cfg_valid / o_cfg_ready with a register index and
// data; write only while no word is in flight. writing the window length
// empties the delay line and the running sums.
// one word at a time: the block stalls its input from acceptance until
// the result is in the output register. with a nonzero window the moving
// average runs the one-bit-per-cycle divider, and the moving rms runs the
// divider and then the square root unit; peak and low-pass use neither.
// a bad channel count gives a zero result.
// the output register frees the core: a new word is taken while a result
// waits; a finished result waits in the sequencer if the output is full.
// reset restores the register defaults and empties the window at once,
// through a fill count instead of clearing the memory.
module sidechain_envelope_detector_unit
    import sedet_pkg::*;
#(
    parameter int MAX_WINDOW  = 4096,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_right_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [SAMPLE_BITS-2:0]        o_envelope,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data
);

    localparam int SB    = SAMPLE_BITS;
    localparam int EW    = SB - 1;
    localparam int MW    = SB + 1;
    localparam int PW    = MW + COEF_BITS;
    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int FW    = $clog2(MAX_WINDOW + 1);
    localparam int NW    = WIN_BITS;
    localparam int CW    = ((AW > NW) ? AW : NW) + 2;
    localparam int ABS_W = EW + AW + 1;
    localparam int SQ_W  = 2 * EW + AW + 1;
    localparam int LPW   = EW + LP_FRAC;
    localparam int RTW   = (SQ_W + 1) / 2;
    localparam logic [EW-1:0] ENV_MAX = '1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MAG    = 4'd1;
    localparam logic [3:0] S_GAIN   = 4'd2;
    localparam logic [3:0] S_SQ     = 4'd3;
    localparam logic [3:0] S_SUM    = 4'd4;
    localparam logic [3:0] S_DSTART = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_RSTART = 4'd7;
    localparam logic [3:0] S_SQRT   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] r_state;

    // configuration
    logic [1:0]           r_chan;
    logic                 r_ms;
    logic [1:0]           r_src;
    logic [1:0]           r_mode;
    logic [NW-1:0]        r_win;
    logic [COEF_BITS-1:0] r_gain;
    logic [COEF_BITS-1:0] r_tau;

    // datapath
    logic signed [SB-1:0] r_a;
    logic signed [SB-1:0] r_b;
    logic [PW-1:0]        r_prod;
    logic [EW-1:0]        r_x;
    logic [EW-1:0]        r_rd;
    logic [2*EW-1:0]      r_xsq;
    logic [2*EW-1:0]      r_osq;
    logic [LPW+COEF_BITS-1:0] r_lpprod;
    logic                 r_lpup;
    logic [LPW-1:0]       r_lp;
    logic [ABS_W-1:0]     r_abs;
    logic [SQ_W-1:0]      r_sqs;
    logic [AW-1:0]        r_wp;
    logic [FW-1:0]        r_fill;
    logic [EW-1:0]        r_env;
    logic                 r_out_valid;
    logic [EW-1:0]        r_out;

    logic [EW-1:0] r_mem [MAX_WINDOW];

    logic signed [MW-1:0] w_a;
    logic signed [MW-1:0] w_b;
    logic signed [MW-1:0] w_sum;
    logic signed [MW-1:0] w_dif;
    logic [MW-1:0]        w_mag;
    logic [PW-1:0]        w_shift;
    logic [EW-1:0]        n_x;
    logic [NW-1:0]        w_n;
    logic                 w_nz;
    logic [CW-1:0]        w_idx;
    logic [AW-1:0]        w_rd_addr;
    logic [EW-1:0]        w_old;
    logic [LPW-1:0]       w_target;
    logic [LPW-1:0]       w_lpdiff;
    logic [LPW-1:0]       n_lp;
    logic [SQ_W-1:0]      n_sqs;
    logic                 w_chan_ok;
    logic                 w_out_free;
    logic                 w_accept;
    logic [SQ_W-1:0]      w_dividend;
    logic [SQ_W-1:0]      w_quot;
    logic [RTW-1:0]       w_root;
    t_unit_sts            w_div_sts;
    t_unit_sts            w_sqrt_sts;

    function automatic logic [MW-1:0] f_abs(input logic signed [MW-1:0] v);
        f_abs = v[MW-1] ? MW'(-v) : MW'(v);
    endfunction

    // source selection and magnitude
    assign w_a   = MW'(r_a);
    assign w_b   = MW'(r_b);
    assign w_sum = w_a + w_b;
    assign w_dif = w_a - w_b;

    always_comb begin
        w_mag = f_abs(w_a);
        if (r_chan == CH_STEREO) begin
            if (r_ms) begin
                case (r_src)
                    SRC_LEFT:  w_mag = f_abs(w_sum);
                    SRC_RIGHT: w_mag = f_abs(w_dif);
                    SRC_MID:   w_mag = f_abs(w_a);
                    default:   w_mag = f_abs(w_b);
                endcase
            end else begin
                case (r_src)
                    SRC_LEFT:  w_mag = f_abs(w_a);
                    SRC_RIGHT: w_mag = f_abs(w_b);
                    SRC_MID:   w_mag = f_abs(w_sum) >> 1;
                    default:   w_mag = f_abs(w_dif) >> 1;
                endcase
            end
        end
    end

    assign w_chan_ok = (r_chan == CH_MONO) || (r_chan == CH_STEREO);

    // gain truncation and saturation
    assign w_shift = r_prod >> GAIN_FRAC;
    assign n_x     = (w_shift > PW'(ENV_MAX)) ? ENV_MAX : w_shift[EW-1:0];

    // effective window and the slot that drops out of it
    assign w_n  = (32'(r_win) > 32'(MAX_WINDOW)) ? NW'(MAX_WINDOW) : r_win;
    assign w_nz = (w_n != '0);
    assign w_idx = (CW'(r_wp) >= CW'(w_n)) ? (CW'(r_wp) - CW'(w_n))
                                           : (CW'(r_wp) + CW'(MAX_WINDOW) - CW'(w_n));
    assign w_rd_addr = w_idx[AW-1:0];
    // slots not written since the window was emptied read as zero
    assign w_old = (CW'(r_fill) >= CW'(w_n)) ? r_rd : '0;

    // low-pass
    assign w_target = {r_x, {LP_FRAC{1'b0}}};
    assign w_lpdiff = (w_target >= r_lp) ? (w_target - r_lp) : (r_lp - w_target);
    assign n_lp     = r_lpup ? (r_lp + r_lpprod[LPW+COEF_BITS-1:COEF_BITS])
                             : (r_lp - r_lpprod[LPW+COEF_BITS-1:COEF_BITS]);
    assign n_sqs    = r_sqs + SQ_W'(r_xsq) - SQ_W'(r_osq);

    assign w_dividend = (r_mode == MODE_AVG) ? SQ_W'(r_abs) : r_sqs;

    sedet_div #(
        .W  (SQ_W),
        .DW (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_DSTART),
        .i_dividend (w_dividend),
        .i_divisor  (w_n),
        .o_sts      (w_div_sts),
        .o_quot     (w_quot)
    );

    sedet_sqrt #(
        .W (SQ_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_RSTART),
        .i_value (w_quot),
        .o_sts   (w_sqrt_sts),
        .o_root  (w_root)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_envelope  = r_out;

    // delay line memory
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[w_rd_addr];
        if (r_state == S_SQ) begin
            r_mem[r_wp] <= r_x;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a <= i_left_sample;
            r_b <= i_right_sample;
        end
        if (r_state == S_MAG) begin
            r_prod <= PW'(w_mag) * PW'(r_gain);
        end
        if (r_state == S_GAIN) begin
            r_x <= n_x;
        end
        if (r_state == S_SQ) begin
            r_xsq    <= r_x * r_x;
            r_osq    <= w_old * w_old;
            r_lpprod <= (LPW + COEF_BITS)'(w_lpdiff) * (LPW + COEF_BITS)'(r_tau);
            r_lpup   <= (w_target >= r_lp);
        end
        if (w_out_free && (r_state == S_OUT)) begin
            r_out <= r_env;
        end
    end

    // sequencer, window state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_chan      <= RST_CHANNELS;
            r_ms        <= RST_MID_SIDE;
            r_src       <= RST_SOURCE;
            r_mode      <= RST_MODE;
            r_win       <= RST_WINDOW;
            r_gain      <= RST_GAIN;
            r_tau       <= RST_TAU;
            r_wp        <= '0;
            r_fill      <= '0;
            r_abs       <= '0;
            r_sqs       <= '0;
            r_lp        <= '0;
            r_env       <= '0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_MAG;
                    end
                end
                S_MAG: begin
                    if (w_chan_ok) begin
                        r_state <= S_GAIN;
                    end else begin
                        r_env   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_GAIN: r_state <= S_SQ;
                S_SQ: begin
                    if (w_nz) begin
                        r_abs <= r_abs + ABS_W'(r_x) - ABS_W'(w_old);
                    end
                    r_wp <= (32'(r_wp) + 1 >= MAX_WINDOW) ? '0 : r_wp + 1'b1;
                    if (32'(r_fill) < MAX_WINDOW) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (w_nz) begin
                        r_sqs <= n_sqs;
                    end
                    r_state <= S_OUT;
                    case (r_mode)
                        MODE_PEAK: r_env <= r_x;
                        MODE_LP: begin
                            r_lp  <= n_lp;
                            r_env <= n_lp[LPW-1:LP_FRAC];
                        end
                        default: begin
                            if (w_nz) begin
                                r_state <= S_DSTART;
                            end else begin
                                r_env <= r_x;
                            end
                        end
                    endcase
                end
                S_DSTART: r_state <= S_DIV;
                S_DIV: begin
                    if (w_div_sts.done) begin
                        if (r_mode == MODE_AVG) begin
                            r_env   <= (w_quot > SQ_W'(ENV_MAX)) ? ENV_MAX : w_quot[EW-1:0];
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RSTART;
                        end
                    end
                end
                S_RSTART: r_state <= S_SQRT;
                S_SQRT: begin
                    if (w_sqrt_sts.done) begin
                        r_env   <= (w_root > RTW'(ENV_MAX)) ? ENV_MAX : w_root[EW-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_CHANNELS: r_chan <= i_cfg_data[1:0];
                    REG_MID_SIDE: r_ms   <= i_cfg_data[0];
                    REG_SOURCE:   r_src  <= i_cfg_data[1:0];
                    REG_MODE:     r_mode <= i_cfg_data[1:0];
                    REG_WINDOW: begin
                        r_win  <= i_cfg_data[NW-1:0];
                        r_wp   <= '0;
                        r_fill <= '0;
                        r_abs  <= '0;
                        r_sqs  <= '0;
                    end
                    REG_GAIN:     r_gain <= i_cfg_data;
                    REG_TAU:      r_tau  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MAG))
        else $error("accepted word did not start the sequence");

    a_div_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    a_sqrt_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_sts.done |-> (r_state == S_SQRT))
        else $error("square root finished outside its wait state");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= MAX_WINDOW)
        else $error("fill count beyond window memory");

endmodule

// File: rtl/sedet_div.sv
module sedet_div
    import sedet_pkg::*;
#(
    parameter int W  = 58,
    parameter int DW = 13
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output t_unit_sts    o_sts,
    output logic [W-1:0] o_quot
);

    localparam int CNTW = $clog2(W + 1);

    logic [DW-1:0]   r_rem;
    logic [W-1:0]    r_q;
    logic [DW-1:0]   r_div;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [DW:0]   w_t;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] n_rem;

    // restoring division, one quotient bit per cycle
    assign w_t    = {r_rem, r_q[W-1]};
    assign w_ge   = w_t >= {1'b0, r_div};
    assign w_diff = w_t - {1'b0, r_div};
    assign n_rem  = w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[W-2:0], w_ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_q;

endmodule

// File: rtl/sedet_sqrt.sv
module sedet_sqrt
    import sedet_pkg::*;
#(
    parameter int W = 58
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [W-1:0]           i_value,
    output t_unit_sts              o_sts,
    output logic [(W+1)/2-1:0]     o_root
);

    localparam int STEPS = (W + 1) / 2;
    localparam int RW    = 2 * STEPS + 1;
    localparam int CNTW  = $clog2(STEPS + 1);

    logic [RW-1:0]   r_v;
    logic [RW-1:0]   r_res;
    logic [RW-1:0]   r_bit;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [RW-1:0] w_trial;
    logic          w_ge;

    // bit-by-bit root, one result bit per cycle
    assign w_trial = r_res + r_bit;
    assign w_ge    = r_v >= w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= RW'(i_value);
            r_res <= '0;
            r_bit <= RW'(1) << (2 * (STEPS - 1));
        end else if (r_busy) begin
            if (w_ge) begin
                r_v   <= r_v - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_root     = r_res[STEPS-1:0];

endmodule
